// ----- rtl/core/smeu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package smeu_pkg;
    localparam int unsigned STACK_DEPTH_DEF = 256;
    localparam int unsigned WORD_W = 32;

    localparam logic [7:0] OP_HALT  = 8'd0;
    localparam logic [7:0] OP_PUSHC = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_SUB   = 8'd3;
    localparam logic [7:0] OP_MUL   = 8'd4;
    localparam logic [7:0] OP_DIV   = 8'd5;
    localparam logic [7:0] OP_MOD   = 8'd6;
    localparam logic [7:0] OP_RDINT = 8'd7;
    localparam logic [7:0] OP_WRINT = 8'd8;
    localparam logic [7:0] OP_RDCHR = 8'd9;
    localparam logic [7:0] OP_WRCHR = 8'd10;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALTED  = 3'd1,
        ST_IGNORED = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_BADOP   = 3'd4,
        ST_UNDER   = 3'd5,
        ST_OVER    = 3'd6
    } status_t;
endpackage
`default_nettype wire

// ----- rtl/core/stack_machine_execute_unit_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  tdata fields (low bit up)                          tuser
// s_axis    in   instruction[31:0], read_value[63:32]                 -
// m_axis    out  status[2:0], out_valid[3], out_value[35:4],          out_is_char[0]
//                depth_now[44:36], zero pad to 48
//
// One transaction is taken at a time. Push, halt, write and rejected
// instructions pass through accept, stack read and output; binary add, sub
// and mul add a second stack read and the execute step, and div or mod add
// the bit-serial divider after the execute step. A zero divisor skips the
// divider.
// Reset (aresetn low, synchronous) clears the stack pointer and the stopped
// flag; stack memory contents are not cleared.
// The result sits in an output register; a new transaction is accepted once
// the previous result has been taken or in the same cycle that it is taken.
module stack_machine_execute_unit_core
    import smeu_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // instruction, read_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // status, out_valid, out_value, depth_now
    output logic [0:0]       m_axis_tuser    // out_is_char
);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_OUT
    } state_t;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    state_t            state_reg;
    logic [PW-1:0]     sp_reg;
    logic              stopped_reg;
    logic [7:0]        op_reg;
    logic [WORD_W-1:0] imm_reg, rv_reg;
    logic [WORD_W-1:0] b_reg;        // top of stack
    logic [WORD_W-1:0] a_reg;        // entry below
    // divider
    logic [WORD_W-1:0] quo_reg, rem_reg, dvs_reg;
    logic [5:0]        cnt_reg;
    logic              neg_q_reg, neg_r_reg;
    // output
    logic              m_valid_reg;
    logic [2:0]        o_status_reg;
    logic              o_valid_reg, o_char_reg;
    logic [WORD_W-1:0] o_value_reg;
    logic [PW-1:0]     o_depth_reg;

    wire logic [7:0] in_op = s_axis_tdata[31:24];
    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    wire logic accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [WORD_W:0] rem_shift;
    logic [WORD_W:0] rem_diff;
    always_comb begin
        rem_shift = {rem_reg, quo_reg[WORD_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
    end

    always_comb begin
        rd_addr = '0;
        if (state_reg == S_IDLE || state_reg == S_RD1) begin
            rd_addr = (state_reg == S_IDLE) ? AW'(sp_reg - 1'b1) : AW'(sp_reg - 2'd2);
        end
    end

    logic is_push, is_wr, is_bin;
    always_comb begin
        is_push = (op_reg == OP_PUSHC) || (op_reg == OP_RDINT) || (op_reg == OP_RDCHR);
        is_wr   = (op_reg == OP_WRINT) || (op_reg == OP_WRCHR);
        is_bin  = (op_reg >= OP_ADD) && (op_reg <= OP_MOD);
    end

    logic [WORD_W-1:0] push_val;
    logic [WORD_W-1:0] prod;
    always_comb begin
        push_val = imm_reg;
        if (op_reg == OP_RDINT) begin
            push_val = rv_reg;
        end else if (op_reg == OP_RDCHR) begin
            push_val = {{(WORD_W-8){rv_reg[7]}}, rv_reg[7:0]};
        end
        prod = a_reg * b_reg;
        mem_we  = 1'b0;
        wr_addr = AW'(sp_reg);
        wr_data = push_val;
        if (state_reg == S_RD1 && !stopped_reg && is_push && sp_reg < PW'(STACK_DEPTH)) begin
            mem_we = 1'b1;
        end else if (state_reg == S_EXEC && (op_reg == OP_ADD || op_reg == OP_SUB
                                             || op_reg == OP_MUL)) begin
            mem_we  = 1'b1;
            wr_addr = AW'(sp_reg - 2'd2);
            wr_data = (op_reg == OP_ADD) ? a_reg + b_reg :
                      (op_reg == OP_SUB) ? a_reg - b_reg : prod;
        end else if (state_reg == S_DIV && cnt_reg == 6'd0) begin
            mem_we  = 1'b1;
            wr_addr = AW'(sp_reg - 2'd2);
            wr_data = (op_reg == OP_DIV) ? (neg_q_reg ? ~quo_reg + 1'b1 : quo_reg)
                                         : (neg_r_reg ? ~rem_reg + 1'b1 : rem_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= in_op;
                        imm_reg   <= {{8{s_axis_tdata[23]}}, s_axis_tdata[23:0]};
                        rv_reg    <= s_axis_tdata[63:32];
                        state_reg <= S_RD1;
                    end
                end
                S_RD1: begin
                    b_reg        <= rd_data_reg;
                    o_valid_reg  <= 1'b0;
                    o_char_reg   <= 1'b0;
                    o_value_reg  <= '0;
                    o_status_reg <= ST_OK;
                    state_reg    <= S_OUT;
                    if (stopped_reg) begin
                        o_status_reg <= ST_IGNORED;
                    end else if (op_reg == OP_HALT) begin
                        stopped_reg  <= 1'b1;
                        o_status_reg <= ST_HALTED;
                    end else if (is_push) begin
                        if (sp_reg >= PW'(STACK_DEPTH)) begin
                            stopped_reg  <= 1'b1;
                            o_status_reg <= ST_OVER;
                        end else begin
                            sp_reg <= sp_reg + 1'b1;
                        end
                    end else if (is_wr) begin
                        if (sp_reg == '0) begin
                            stopped_reg  <= 1'b1;
                            o_status_reg <= ST_UNDER;
                        end else begin
                            sp_reg      <= sp_reg - 1'b1;
                            o_valid_reg <= 1'b1;
                            o_char_reg  <= (op_reg == OP_WRCHR);
                            o_value_reg <= rd_data_reg;
                        end
                    end else if (is_bin) begin
                        if (sp_reg < PW'(2)) begin
                            stopped_reg  <= 1'b1;
                            o_status_reg <= ST_UNDER;
                        end else begin
                            state_reg <= S_RD2;
                        end
                    end else begin
                        stopped_reg  <= 1'b1;
                        o_status_reg <= ST_BADOP;
                    end
                end
                S_RD2: begin
                    a_reg     <= rd_data_reg;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    if (op_reg == OP_DIV || op_reg == OP_MOD) begin
                        if (b_reg == '0) begin
                            stopped_reg  <= 1'b1;
                            o_status_reg <= ST_DIVZERO;
                            state_reg    <= S_OUT;
                        end else begin
                            quo_reg   <= mag(a_reg);
                            dvs_reg   <= mag(b_reg);
                            rem_reg   <= '0;
                            neg_q_reg <= a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
                            neg_r_reg <= a_reg[WORD_W-1];
                            cnt_reg   <= 6'(WORD_W);
                            state_reg <= S_DIV;
                        end
                    end else begin
                        sp_reg    <= sp_reg - 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (cnt_reg == 6'd0) begin
                        sp_reg    <= sp_reg - 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                        if (!rem_diff[WORD_W]) begin
                            rem_reg <= rem_diff[WORD_W-1:0];
                            quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_shift[WORD_W-1:0];
                            quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
                        end
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        o_depth_reg <= sp_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic [8:0] depth9;
    assign depth9 = 9'(o_depth_reg);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, depth9, o_value_reg, o_valid_reg, o_status_reg};
    assign m_axis_tuser  = o_char_reg;

`ifndef ASSERT_OFF
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= PW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg) else $error("stopped flag cleared");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_stopped_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (stopped_reg && state_reg == S_RD1) |-> !mem_we) else $error("write while stopped");
`endif
endmodule
`default_nettype wire
